// File: rtl/core/kvp_pkg.sv
`default_nettype none

package kvp_pkg;

   localparam logic [15:0] HDR_LEN   = 16'd8;
   localparam logic [15:0] POS_MAX   = 16'hFFFF;
   localparam logic [23:0] TOK_SET   = 24'h736574;
   localparam logic [23:0] TOK_GET   = 24'h676574;
   localparam logic [7:0]  CH_SPACE  = 8'h20;
   localparam logic [7:0]  CH_CR     = 8'h0D;
   localparam logic [7:0]  CH_LF     = 8'h0A;
   localparam logic [7:0]  CH_N      = 8'h6E;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_NINE   = 8'h39;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_CLIENT  = 2'd1,
      KIND_GET     = 2'd2,
      KIND_SET     = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      RSN_NONE      = 4'd0,
      RSN_DATAGRAMS = 4'd1,
      RSN_REQUEST   = 4'd2,
      RSN_KEY       = 4'd3,
      RSN_FLAGS     = 4'd4,
      RSN_TIME      = 4'd5,
      RSN_BYTES     = 4'd6,
      RSN_REPLY     = 4'd7,
      RSN_SIZE      = 4'd8
   } reason_type;

   typedef enum logic [13:0] {
      ST_HEADER   = 14'b00000000000001,
      ST_CMD      = 14'b00000000000010,
      ST_SET_KEY  = 14'b00000000000100,
      ST_FLAGS    = 14'b00000000001000,
      ST_TIME     = 14'b00000000010000,
      ST_BYTES    = 14'b00000000100000,
      ST_REPLY    = 14'b00000001000000,
      ST_REPLY_LF = 14'b00000010000000,
      ST_BYTES_LF = 14'b00000100000000,
      ST_VALUE    = 14'b00001000000000,
      ST_GET_KEY  = 14'b00010000000000,
      ST_GET_DONE = 14'b00100000000000,
      ST_ERR      = 14'b01000000000000,
      ST_UNKNOWN  = 14'b10000000000000
   } stage_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  command_kind;
      logic [3:0]  error_reason;
      logic [15:0] key_offset;
      logic [15:0] key_length;
      logic [31:0] client_flags;
      logic        no_reply;
      logic [15:0] data_offset;
      logic [31:0] data_length;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/kvp_req_if.sv
`default_nettype none

interface kvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/kvp_rsp_if.sv
`default_nettype none

interface kvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command_kind;
   logic [3:0]  error_reason;
   logic [15:0] key_offset;
   logic [15:0] key_length;
   logic [31:0] client_flags;
   logic        no_reply;
   logic [15:0] data_offset;
   logic [31:0] data_length;

   modport source (
      output valid, output command_kind, output error_reason, output key_offset,
      output key_length, output client_flags, output no_reply, output data_offset,
      output data_length, input ready
   );
   modport sink (
      input valid, input command_kind, input error_reason, input key_offset,
      input key_length, input client_flags, input no_reply, input data_offset,
      input data_length, output ready
   );
endinterface

`default_nettype wire

// File: rtl/core/kvp_input_stage.sv
`default_nettype none

module kvp_input_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire kvp_pkg::req_type req_data,
   output logic                  req_ready,
   input  wire logic             consume,
   output logic                  in_valid,
   output kvp_pkg::req_type      in_data
);
   import kvp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_ready = !valid_ff || consume;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;
endmodule

`default_nettype wire

// File: rtl/core/kvp_parser.sv
`default_nettype none

module kvp_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire kvp_pkg::req_type in_data,
   input  wire logic             out_free,
   output logic                  consume,
   output logic                  rsp_load,
   output kvp_pkg::rsp_type      rsp_data
);
   import kvp_pkg::*;

   stage_type  stage_ff, stage_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  cnt_hi_ff, cnt_hi_in;
   logic [23:0] tok_ff, tok_in;
   logic [2:0]  tok_len_ff, tok_len_in;
   logic [15:0] key_start_ff, key_start_in;
   logic [15:0] key_size_ff, key_size_in;
   logic [31:0] flags_ff, flags_in;
   logic [31:0] bytes_ff, bytes_in;
   logic        noreply_ff, noreply_in;
   reason_type  err_ff, err_in;
   logic [15:0] value_start_ff, value_start_in;
   logic        digit_run_ff, digit_run_in;

   logic [7:0]  b;
   logic        is_digit;
   logic        digit_ok;
   logic [31:0] acc;
   logic [35:0] prod;
   logic [31:0] acc_next;
   logic [16:0] avail_diff;
   logic [15:0] avail;
   logic [15:0] key_size_inc;

   assign b         = in_data.byte_in;
   assign consume   = in_valid && (!in_data.last_byte || out_free);
   assign rsp_load  = consume && in_data.last_byte;

   // decimal accumulate with saturation
   assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
   assign digit_ok  = digit_run_ff && is_digit;
   assign acc       = (stage_ff == ST_FLAGS) ? flags_ff : bytes_ff;
   assign prod      = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
                      + {32'd0, b[3:0] - CH_ZERO[3:0]};
   assign acc_next  = (|prod[35:32]) ? 32'hFFFF_FFFF : prod[31:0];
   assign key_size_inc = key_size_ff + {15'd0, key_size_ff != POS_MAX};

   always_comb begin
      stage_in       = stage_ff;
      pos_in         = pos_ff + {15'd0, pos_ff != POS_MAX};
      cnt_hi_in      = cnt_hi_ff;
      tok_in         = tok_ff;
      tok_len_in     = tok_len_ff;
      key_start_in   = key_start_ff;
      key_size_in    = key_size_ff;
      flags_in       = flags_ff;
      bytes_in       = bytes_ff;
      noreply_in     = noreply_ff;
      err_in         = err_ff;
      value_start_in = value_start_ff;
      digit_run_in   = digit_run_ff;

      case (stage_ff)
         ST_HEADER: begin
            if (pos_ff == 16'd4) begin
               cnt_hi_in = b;
            end
            if (pos_ff == 16'd5 && (cnt_hi_ff != 8'd0 || b != 8'd1)) begin
               err_in   = RSN_DATAGRAMS;
               stage_in = ST_ERR;
            end else if (pos_ff == HDR_LEN - 16'd1) begin
               stage_in = ST_CMD;
            end
         end
         ST_CMD: begin
            if (b == CH_SPACE) begin
               key_start_in = pos_in;
               if (tok_len_ff == 3'd3 && tok_ff == TOK_SET) begin
                  stage_in = ST_SET_KEY;
               end else if (tok_len_ff == 3'd3 && tok_ff == TOK_GET) begin
                  stage_in = ST_GET_KEY;
               end else begin
                  stage_in = ST_UNKNOWN;
               end
            end else begin
               if (tok_len_ff < 3'd3) begin
                  tok_in = {tok_ff[15:0], b};
               end
               if (tok_len_ff < 3'd4) begin
                  tok_len_in = tok_len_ff + 3'd1;
               end
            end
         end
         ST_SET_KEY: begin
            if (b == CH_SPACE) begin
               stage_in     = ST_FLAGS;
               digit_run_in = 1'b1;
            end else begin
               key_size_in = key_size_inc;
            end
         end
         ST_FLAGS: begin
            if (b == CH_SPACE) begin
               stage_in = ST_TIME;
            end else if (digit_ok) begin
               flags_in = acc_next;
            end else begin
               digit_run_in = 1'b0;
            end
         end
         ST_TIME: begin
            if (b == CH_SPACE) begin
               stage_in     = ST_BYTES;
               digit_run_in = 1'b1;
            end
         end
         ST_BYTES: begin
            if (b == CH_SPACE) begin
               stage_in   = ST_REPLY;
               tok_len_in = 3'd0;
            end else if (b == CH_CR) begin
               stage_in = ST_BYTES_LF;
            end else if (digit_ok) begin
               bytes_in = acc_next;
            end else begin
               digit_run_in = 1'b0;
            end
         end
         ST_REPLY: begin
            if (tok_len_ff == 3'd0) begin
               noreply_in = (b == CH_N);
               tok_len_in = 3'd1;
            end
            if (b == CH_CR) begin
               stage_in = ST_REPLY_LF;
            end
         end
         ST_REPLY_LF: begin
            if (b == CH_LF) begin
               value_start_in = pos_in;
               stage_in       = ST_VALUE;
            end else begin
               err_in   = RSN_REPLY;
               stage_in = ST_ERR;
            end
         end
         ST_BYTES_LF: begin
            value_start_in = pos_in;
            stage_in       = ST_VALUE;
         end
         ST_GET_KEY: begin
            if (b == CH_SPACE || b == CH_CR) begin
               stage_in = ST_GET_DONE;
            end else begin
               key_size_in = key_size_inc;
            end
         end
         default: begin
         end
      endcase
   end

   assign avail_diff = {1'b0, pos_in} - {1'b0, value_start_in};
   assign avail      = avail_diff[16] ? 16'd0 : avail_diff[15:0];

   always_comb begin
      rsp_data              = '0;
      rsp_data.command_kind = KIND_CLIENT;
      rsp_data.error_reason = RSN_NONE;
      case (stage_in)
         ST_HEADER:   rsp_data.error_reason = RSN_DATAGRAMS;
         ST_CMD:      rsp_data.error_reason = RSN_REQUEST;
         ST_SET_KEY:  rsp_data.error_reason = RSN_KEY;
         ST_GET_KEY:  rsp_data.error_reason = RSN_KEY;
         ST_FLAGS:    rsp_data.error_reason = RSN_FLAGS;
         ST_TIME:     rsp_data.error_reason = RSN_TIME;
         ST_BYTES:    rsp_data.error_reason = RSN_BYTES;
         ST_BYTES_LF: rsp_data.error_reason = RSN_BYTES;
         ST_REPLY:    rsp_data.error_reason = RSN_REPLY;
         ST_REPLY_LF: rsp_data.error_reason = RSN_REPLY;
         ST_ERR:      rsp_data.error_reason = err_in;
         ST_UNKNOWN:  rsp_data.command_kind = KIND_UNKNOWN;
         ST_GET_DONE: begin
            rsp_data.command_kind = KIND_GET;
            rsp_data.key_offset   = key_start_in;
            rsp_data.key_length   = key_size_in;
         end
         ST_VALUE: begin
            if ({16'd0, avail} < bytes_in) begin
               rsp_data.error_reason = RSN_SIZE;
            end else begin
               rsp_data.command_kind = KIND_SET;
               rsp_data.key_offset   = key_start_in;
               rsp_data.key_length   = key_size_in;
               rsp_data.client_flags = flags_in;
               rsp_data.no_reply     = noreply_in;
               rsp_data.data_offset  = value_start_in;
               rsp_data.data_length  = bytes_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || rsp_load) begin
         stage_ff       <= ST_HEADER;
         pos_ff         <= '0;
         cnt_hi_ff      <= '0;
         tok_ff         <= '0;
         tok_len_ff     <= '0;
         key_start_ff   <= '0;
         key_size_ff    <= '0;
         flags_ff       <= '0;
         bytes_ff       <= '0;
         noreply_ff     <= 1'b0;
         err_ff         <= RSN_NONE;
         value_start_ff <= '0;
         digit_run_ff   <= 1'b0;
      end else if (consume) begin
         stage_ff       <= stage_in;
         pos_ff         <= pos_in;
         cnt_hi_ff      <= cnt_hi_in;
         tok_ff         <= tok_in;
         tok_len_ff     <= tok_len_in;
         key_start_ff   <= key_start_in;
         key_size_ff    <= key_size_in;
         flags_ff       <= flags_in;
         bytes_ff       <= bytes_in;
         noreply_ff     <= noreply_in;
         err_ff         <= err_in;
         value_start_ff <= value_start_in;
         digit_run_ff   <= digit_run_in;
      end
   end
endmodule

`default_nettype wire

// File: rtl/core/kvp_output_stage.sv
`default_nettype none

module kvp_output_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rsp_load,
   input  wire kvp_pkg::rsp_type rsp_data,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output kvp_pkg::rsp_type      rsp_out,
   output logic                  out_free
);
   import kvp_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = rsp_load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         data_ff <= rsp_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;
endmodule

`default_nettype wire

// File: rtl/core/kv_text_request_parser_core.sv
// result path: input register, parse logic, then the result register
// throughput: one byte per cycle, set by the single parse stage between the input and
//    result registers; a last byte waits only while a previous result is still unread
// reset: synchronous active high, clears both valid flags and returns the parser to the
//    frame header state; the parser also returns there after every last byte
`default_nettype none

module kv_text_request_parser_core (
   input  wire logic clock,
   input  wire logic reset,
   kvp_req_if.sink   req_ch,
   kvp_rsp_if.source rsp_ch
);
   import kvp_pkg::*;

   req_type req_data;
   req_type in_data;
   rsp_type rsp_data;
   rsp_type rsp_out;
   logic    in_valid;
   logic    consume;
   logic    rsp_load;
   logic    out_free;

   assign req_data.byte_in   = req_ch.byte_in;
   assign req_data.last_byte = req_ch.last_byte;

   kvp_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_data  (req_data),
      .req_ready (req_ch.ready),
      .consume   (consume),
      .in_valid  (in_valid),
      .in_data   (in_data)
   );

   kvp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_data  (in_data),
      .out_free (out_free),
      .consume  (consume),
      .rsp_load (rsp_load),
      .rsp_data (rsp_data)
   );

   kvp_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .rsp_load  (rsp_load),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_out   (rsp_out),
      .out_free  (out_free)
   );

   assign rsp_ch.command_kind = rsp_out.command_kind;
   assign rsp_ch.error_reason = rsp_out.error_reason;
   assign rsp_ch.key_offset   = rsp_out.key_offset;
   assign rsp_ch.key_length   = rsp_out.key_length;
   assign rsp_ch.client_flags = rsp_out.client_flags;
   assign rsp_ch.no_reply     = rsp_out.no_reply;
   assign rsp_ch.data_offset  = rsp_out.data_offset;
   assign rsp_ch.data_length  = rsp_out.data_length;
endmodule

`default_nettype wire

// File: tb/kv_text_request_parser_core_tb.sv
module kv_text_request_parser_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kvp_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PRINT_CAP   = 50;

   logic clock;
   logic reset;

   kvp_req_if req_ch();
   kvp_rsp_if rsp_ch();

   kv_text_request_parser_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the parser state
   stage_type   sh_stage;
   logic [15:0] sh_pos;
   logic [7:0]  sh_count_hi;
   logic [23:0] sh_token;
   logic [2:0]  sh_tok_len;
   logic [15:0] sh_key_start;
   logic [15:0] sh_key_size;
   logic [31:0] sh_flags;
   logic [31:0] sh_bytes;
   logic        sh_noreply;
   reason_type  sh_err;
   logic [15:0] sh_value_start;
   logic        sh_digits;

   rsp_type     parsed_rsp_q[$];
   logic [7:0]  frame_bytes[$];

   int mismatches;
   int results_seen;
   int frames_sent;
   int bytes_sent;
   int burst_left;
   int cycle_count;
   int stall_mode;
   int stall_left;
   int kind_count[4];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task shadow_clear();
      sh_stage       = ST_HEADER;
      sh_pos         = '0;
      sh_count_hi    = '0;
      sh_token       = '0;
      sh_tok_len     = '0;
      sh_key_start   = '0;
      sh_key_size    = '0;
      sh_flags       = '0;
      sh_bytes       = '0;
      sh_noreply     = 1'b0;
      sh_err         = RSN_NONE;
      sh_value_start = '0;
      sh_digits      = 1'b0;
   endtask

   function logic [31:0] next_decimal(input logic [31:0] acc, input logic [7:0] b);
      logic [35:0] v;
      if (!sh_digits || b < CH_ZERO || b > CH_NINE) begin
         sh_digits = 1'b0;
         return acc;
      end
      v = {4'd0, acc} * 36'd10 + {28'd0, b - CH_ZERO};
      if (v > 36'hFFFFFFFF) return 32'hFFFFFFFF;
      return v[31:0];
   endfunction

   task shadow_parse_byte(input logic [7:0] b, input logic last);
      logic [15:0] pos;
      logic [15:0] avail;
      rsp_type     r;
      pos = sh_pos;
      if (sh_pos != POS_MAX) sh_pos = sh_pos + 16'd1;
      case (sh_stage)
         ST_HEADER: begin
            if (pos == 16'd4) sh_count_hi = b;
            if (pos == 16'd5 && (sh_count_hi != 8'd0 || b != 8'd1)) begin
               sh_err   = RSN_DATAGRAMS;
               sh_stage = ST_ERR;
            end else if (pos == HDR_LEN - 16'd1) begin
               sh_stage = ST_CMD;
            end
         end
         ST_CMD: begin
            if (b == CH_SPACE) begin
               sh_key_start = sh_pos;
               if (sh_tok_len == 3'd3 && sh_token == TOK_SET) sh_stage = ST_SET_KEY;
               else if (sh_tok_len == 3'd3 && sh_token == TOK_GET) sh_stage = ST_GET_KEY;
               else sh_stage = ST_UNKNOWN;
            end else begin
               if (sh_tok_len < 3'd3) sh_token = {sh_token[15:0], b};
               if (sh_tok_len < 3'd4) sh_tok_len = sh_tok_len + 3'd1;
            end
         end
         ST_SET_KEY: begin
            if (b == CH_SPACE) begin
               sh_stage  = ST_FLAGS;
               sh_digits = 1'b1;
            end else if (sh_key_size != POS_MAX) begin
               sh_key_size = sh_key_size + 16'd1;
            end
         end
         ST_FLAGS: begin
            if (b == CH_SPACE) sh_stage = ST_TIME;
            else sh_flags = next_decimal(sh_flags, b);
         end
         ST_TIME: begin
            if (b == CH_SPACE) begin
               sh_stage  = ST_BYTES;
               sh_digits = 1'b1;
            end
         end
         ST_BYTES: begin
            if (b == CH_SPACE) begin
               sh_stage   = ST_REPLY;
               sh_tok_len = '0;
            end else if (b == CH_CR) begin
               sh_stage = ST_BYTES_LF;
            end else begin
               sh_bytes = next_decimal(sh_bytes, b);
            end
         end
         ST_REPLY: begin
            // first letter of the reply token decides noreply
            if (sh_tok_len == 3'd0) begin
               sh_noreply = (b == CH_N);
               sh_tok_len = 3'd1;
            end
            if (b == CH_CR) sh_stage = ST_REPLY_LF;
         end
         ST_REPLY_LF: begin
            if (b == CH_LF) begin
               sh_value_start = sh_pos;
               sh_stage       = ST_VALUE;
            end else begin
               sh_err   = RSN_REPLY;
               sh_stage = ST_ERR;
            end
         end
         ST_BYTES_LF: begin
            sh_value_start = sh_pos;
            sh_stage       = ST_VALUE;
         end
         ST_GET_KEY: begin
            if (b == CH_SPACE || b == CH_CR) sh_stage = ST_GET_DONE;
            else if (sh_key_size != POS_MAX) sh_key_size = sh_key_size + 16'd1;
         end
         default: ;
      endcase

      if (last) begin
         r = '0;
         r.command_kind = KIND_CLIENT;
         r.error_reason = RSN_NONE;
         case (sh_stage)
            ST_HEADER:               r.error_reason = RSN_DATAGRAMS;
            ST_CMD:                  r.error_reason = RSN_REQUEST;
            ST_SET_KEY, ST_GET_KEY:  r.error_reason = RSN_KEY;
            ST_FLAGS:                r.error_reason = RSN_FLAGS;
            ST_TIME:                 r.error_reason = RSN_TIME;
            ST_BYTES, ST_BYTES_LF:   r.error_reason = RSN_BYTES;
            ST_REPLY, ST_REPLY_LF:   r.error_reason = RSN_REPLY;
            ST_ERR:                  r.error_reason = sh_err;
            ST_UNKNOWN:              r.command_kind = KIND_UNKNOWN;
            ST_GET_DONE: begin
               r.command_kind = KIND_GET;
               r.key_offset   = sh_key_start;
               r.key_length   = sh_key_size;
            end
            default: begin
               avail = (sh_pos >= sh_value_start) ? sh_pos - sh_value_start : 16'd0;
               if ({16'd0, avail} < sh_bytes) begin
                  r.error_reason = RSN_SIZE;
               end else begin
                  r.command_kind = KIND_SET;
                  r.key_offset   = sh_key_start;
                  r.key_length   = sh_key_size;
                  r.client_flags = sh_flags;
                  r.no_reply     = sh_noreply;
                  r.data_offset  = sh_value_start;
                  r.data_length  = sh_bytes;
               end
            end
         endcase
         parsed_rsp_q.push_back(r);
         shadow_clear();
      end
   endtask

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      // only the first few are printed
      if (mismatches <= PRINT_CAP)
         $display("result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
   endtask

   task check_result();
      rsp_type want;
      if (parsed_rsp_q.size() == 0) begin
         report_mismatch("result with none pending", 32'(rsp_ch.command_kind), 32'd0);
         return;
      end
      want = parsed_rsp_q.pop_front();
      results_seen++;
      kind_count[want.command_kind]++;
      if (rsp_ch.command_kind !== want.command_kind)
         report_mismatch("command_kind", 32'(rsp_ch.command_kind), 32'(want.command_kind));
      if (rsp_ch.error_reason !== want.error_reason)
         report_mismatch("error_reason", 32'(rsp_ch.error_reason), 32'(want.error_reason));
      if (rsp_ch.key_offset !== want.key_offset)
         report_mismatch("key_offset", 32'(rsp_ch.key_offset), 32'(want.key_offset));
      if (rsp_ch.key_length !== want.key_length)
         report_mismatch("key_length", 32'(rsp_ch.key_length), 32'(want.key_length));
      if (rsp_ch.client_flags !== want.client_flags)
         report_mismatch("client_flags", rsp_ch.client_flags, want.client_flags);
      if (rsp_ch.no_reply !== want.no_reply)
         report_mismatch("no_reply", 32'(rsp_ch.no_reply), 32'(want.no_reply));
      if (rsp_ch.data_offset !== want.data_offset)
         report_mismatch("data_offset", 32'(rsp_ch.data_offset), 32'(want.data_offset));
      if (rsp_ch.data_length !== want.data_length)
         report_mismatch("data_length", rsp_ch.data_length, want.data_length);
   endtask

   // receiver: checks each accepted transaction and stalls in changing modes
   initial begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) check_result();
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     parsed_rsp_q.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_ch.valid     <= 1'b1;
      req_ch.byte_in   <= b;
      req_ch.last_byte <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
      shadow_parse_byte(b, last);
   endtask

   task put_byte(input logic [7:0] b);
      frame_bytes.push_back(b);
   endtask

   task put_text(input string s);
      for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
   endtask

   task put_header(input logic [7:0] count_hi, input logic [7:0] count_lo);
      repeat (4) put_byte(8'($urandom_range(0, 255)));
      put_byte(count_hi);
      put_byte(count_lo);
      repeat (2) put_byte(8'($urandom_range(0, 255)));
   endtask

   task send_frame();
      int n;
      n = frame_bytes.size();
      for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1);
      frame_bytes.delete();
      frames_sent++;
   endtask

   task send_text_frame(input string s);
      put_header(8'd0, 8'd1);
      put_text(s);
      send_frame();
   endtask

   task put_random_key(input int n, input bit for_get);
      logic [7:0] c;
      repeat (n) begin
         if ($urandom_range(0, 7) != 0) begin
            c = 8'($urandom_range(33, 126));
         end else begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_SPACE || (for_get && c == CH_CR));
         end
         put_byte(c);
      end
   endtask

   function string decimal_text();
      string s;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: s = $sformatf("%0d", $urandom_range(0, 99));
         4, 5:       s = $sformatf("%0d", $urandom);
         6:          s = "4294967295";
         7:          s = $sformatf("9%0d", $urandom_range(100000000, 999999999));
         8:          s = $sformatf("%0dx5", $urandom_range(0, 999));
         default:    s = "z9";
      endcase
      return s;
   endfunction

   task build_random_set();
      int         n;
      int         vlen;
      logic [7:0] c;
      put_header(8'd0, 8'd1);
      put_text("set ");
      put_random_key($urandom_range(0, 8), 1'b0);
      put_text(" ");
      put_text(decimal_text());
      put_text(" ");
      put_text($sformatf("%0d ", $urandom_range(0, 86400)));
      if ($urandom_range(0, 4) == 0) begin
         put_text(decimal_text());
         n = -1;
      end else begin
         n = $urandom_range(0, 6);
         put_text($sformatf("%0d", n));
      end
      case ($urandom_range(0, 9))
         0: begin
            put_byte(CH_CR);
            put_byte(8'($urandom_range(0, 255)));
         end
         1, 2: put_text(" noreply\015\012");
         3:    put_text(" n\015\012");
         4: begin
            put_text(" ");
            put_random_key($urandom_range(1, 6), 1'b1);
            put_text("\015\012");
         end
         5: begin
            put_text(" noreply\015");
            do c = 8'($urandom_range(0, 255));
            while (c == CH_LF);
            put_byte(c);
         end
         default: put_text("\015\012");
      endcase
      if (n < 0) vlen = $urandom_range(0, 4);
      else if (n > 0 && $urandom_range(0, 5) == 0) vlen = $urandom_range(0, n - 1);
      else vlen = n + $urandom_range(0, 2);
      repeat (vlen) put_byte(8'($urandom_range(0, 255)));
   endtask

   task build_random_get();
      put_header(8'd0, 8'd1);
      put_text("get ");
      put_random_key($urandom_range(0, 8), 1'b1);
      case ($urandom_range(0, 3))
         0: put_text("\015\012");
         1: begin
            put_text(" ");
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
         end
         2: ;
         default: begin
            put_byte(CH_CR);
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   task build_noise(input bit good_header);
      if (good_header) put_header(8'd0, 8'd1);
      else put_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 30)) put_byte(8'($urandom_range(0, 255)));
   endtask

   task test_set_requests();
      send_text_frame("set key1 17 0 3\015\012abc");
      send_text_frame("set k 5 100 2 noreply\015\012hi");
      send_text_frame("set k 1 2 0 xyz\015\012");
      send_text_frame("set  0 0 0\015\012");
      put_header(8'd0, 8'd1);
      put_text("set k 4294967295 0 1\015\012");
      put_byte(8'hFF);
      send_frame();
      put_header(8'd0, 8'd1);
      put_text("set k 0 0 1\015\012");
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(8'hFF);
      send_frame();
   endtask

   task test_get_requests();
      send_text_frame("get mykey\015\012");
      send_text_frame("get a b c");
      send_text_frame("get \015");
      send_text_frame("get k\015trailing");
   endtask

   task test_unknown_commands();
      send_text_frame("sett k 1 2 3\015\012");
      send_text_frame("ge k");
      send_text_frame(" k");
      send_text_frame("GET k");
      send_text_frame("xset k 0 0 0\015\012");
      send_text_frame("seta");
   endtask

   task test_header_errors();
      put_byte(8'h00);
      send_frame();
      repeat (7) put_byte(8'($urandom_range(0, 255)));
      send_frame();
      put_header(8'd0, 8'd1);
      send_frame();
      put_header(8'd1, 8'd1);
      put_text("get k\015\012");
      send_frame();
      put_header(8'd0, 8'd2);
      send_frame();
      put_header(8'd0, 8'd0);
      send_frame();
      put_header(8'hFF, 8'hFF);
      send_frame();
   endtask

   task test_early_ends();
      send_text_frame("set");
      send_text_frame("set ke");
      send_text_frame("set key 1");
      send_text_frame("set key 12 3");
      send_text_frame("set key 12 34 5");
      send_text_frame("set key 12 34 56\015");
      send_text_frame("set key 12 34 56 no");
      send_text_frame("set key 12 34 56 noreply\015");
   endtask

   task test_line_ends();
      send_text_frame("set k 1 2 3\015Xabc");
      send_text_frame("set k 1 2 3 noreply\015Xabc");
      send_text_frame("set k 0 0 5\015\012abc");
      send_text_frame("set k 0 0 2\015\012");
   endtask

   task test_decimal_fields();
      send_text_frame("set k 99999999999 0 2\015\012ab");
      send_text_frame("set k 12ab3 0 2x9\015\012ab");
      send_text_frame("set k a12 0 z\015\012");
      send_text_frame("set k 4294967296 0 4294967296\015\012xy");
   endtask

   task test_random_traffic();
      int pick;
      int cut;
      int rnd_frames;
      int rnd_bytes;
      rnd_frames = 0;
      rnd_bytes  = 0;
      while (rnd_bytes < 150 || rnd_frames < 6) begin
         pick = $urandom_range(0, 19);
         if (pick < 9) begin
            build_random_set();
         end else if (pick < 13) begin
            build_random_get();
         end else if (pick < 16) begin
            // random set or get request truncated to a random length
            if ($urandom_range(0, 1) != 0) build_random_set();
            else build_random_get();
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end else if (pick < 18) begin
            build_noise(1'b1);
         end else if (pick == 18) begin
            build_noise(1'b0);
         end else begin
            repeat ($urandom_range(1, 9)) put_byte(8'($urandom_range(0, 255)));
         end
         rnd_bytes += frame_bytes.size();
         rnd_frames++;
         send_frame();
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.byte_in   <= 8'd0;
      req_ch.last_byte <= 1'b0;
      mismatches   = 0;
      results_seen = 0;
      frames_sent  = 0;
      bytes_sent   = 0;
      burst_left   = 0;
      for (int k = 0; k < 4; k++) kind_count[k] = 0;
      shadow_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_set_requests();
      test_get_requests();
      test_unknown_commands();
      test_header_errors();
      test_early_ends();
      test_line_ends();
      test_decimal_fields();
      test_random_traffic();

      req_ch.valid <= 1'b0;
      while (parsed_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d datagrams, %0d bytes: header, command, field, line end and size cases",
               frames_sent, bytes_sent);
      $display("checked %0d results: %0d set, %0d get, %0d client error, %0d unknown",
               results_seen, kind_count[KIND_SET], kind_count[KIND_GET],
               kind_count[KIND_CLIENT], kind_count[KIND_UNKNOWN]);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/kvp_pkg.sv
rtl/core/kvp_req_if.sv
rtl/core/kvp_rsp_if.sv
rtl/core/kvp_input_stage.sv
rtl/core/kvp_parser.sv
rtl/core/kvp_output_stage.sv
rtl/core/kv_text_request_parser_core.sv
tb/kv_text_request_parser_core_tb.sv
